// ----- hw/rtl/tcds_pkg.sv -----
// ---------------------------------------------------------------------------
// tcds_pkg: shared definitions for the table change delta scanner
// Command and result codes, the controller state type and default sizes.
// ---------------------------------------------------------------------------
package tcds_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int BEAT_CAP_DEF    = 64;
    localparam int CHUNK_SIZE_DEF  = 64;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 7;
    localparam int LEN_W   = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_SCAN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEED = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PAIR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Register index 0 (table_length) sits at byte address 0.
    localparam logic REG_TABLE_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT0,
        ST_EMIT1
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        count;
    } result_t;

endpackage

// ----- hw/rtl/tcds_ram.sv -----
// ---------------------------------------------------------------------------
// tcds_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module tcds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/table_change_delta_scanner_core.sv -----
// ---------------------------------------------------------------------------
// table_change_delta_scanner_core: shadow table diff engine
// Compares live entries with a RAM-resident shadow copy, or seeds or emits
// them, and reports changed or emitted pairs, dropped notices and batch ends.
// ---------------------------------------------------------------------------
// Timing: an accepted word passes through the compare state, where the shadow
// RAM read data arrives, to the result ports; a second result, if any,
// follows in the next cycle. The core stays busy until its results are out
// and takes no new word before then; pacing is set by the registered read of
// the shadow RAM followed by emission of one result word per cycle.
// Reset clears the controller, the length register and the pass counters;
// the shadow RAM is not cleared and holds garbage until written.
// ---------------------------------------------------------------------------
module table_change_delta_scanner_core #(
    parameter int TABLE_DEPTH = tcds_pkg::TABLE_DEPTH_DEF,
    parameter int BEAT_CAP    = tcds_pkg::BEAT_CAP_DEF,
    parameter int CHUNK_SIZE  = tcds_pkg::CHUNK_SIZE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcds_pkg::PADDR_W-1:0]       paddr,
    input  logic [tcds_pkg::PDATA_W-1:0]       pwdata,
    output logic [tcds_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [tcds_pkg::CMD_W-1:0]         cmd,
    input  logic [tcds_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [tcds_pkg::VAL_W-1:0]  live_value,
    input  logic                               pass_last,
    output logic                               strobe,
    output logic [tcds_pkg::KIND_W-1:0]        kind,
    output logic [tcds_pkg::IDX_W-1:0]         out_index,
    output logic signed [tcds_pkg::VAL_W-1:0]  out_value,
    output logic [tcds_pkg::CNT_W-1:0]         batch_count
);
    import tcds_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Configuration port
    logic [LEN_W-1:0] table_length_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_TABLE_LENGTH))
        begin
            table_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_TABLE_LENGTH)
        begin
            prdata = {{(PDATA_W-LEN_W){1'b0}}, table_length_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Controller state
    state_t           state_reg;
    state_t           state_next;
    logic [LEN_W-1:0] seeded_length_reg;
    logic [LEN_W-1:0] seeded_length_next;
    logic [CNT_W-1:0] pair_count_reg;
    logic [CNT_W-1:0] pair_count_next;
    logic             reseeding_reg;
    logic             reseeding_next;

    // Accepted word
    logic [CMD_W-1:0]        cmd_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    last_reg;

    // Pending results
    result_t    res_reg  [2];
    result_t    res_next [2];
    logic [1:0] n_res;
    logic [1:0] n_res_reg;

    logic             accept;
    logic             entry_valid;
    logic             ram_we;
    logic [VAL_W-1:0] ram_rdata;
    logic [CNT_W-1:0] pc_inc;

    assign accept = start && !busy;

    // The shadow is written in the compare cycle, and the next read can only
    // be issued at a later accept, so a read never overtakes a write.
    tcds_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(idx_reg)),
        .wdata (val_reg),
        .re    (accept),
        .raddr (AW'(entry_index)),
        .rdata (ram_rdata)
    );

    assign entry_valid = ({1'b0, idx_reg} < table_length_reg) &&
                         (17'(idx_reg) < 17'(TABLE_DEPTH));
    assign pc_inc      = pair_count_reg + 7'd1;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            idx_reg  <= entry_index;
            val_reg  <= live_value;
            last_reg <= pass_last;
        end
        if (state_reg == ST_CMP)
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            seeded_length_reg <= '0;
            pair_count_reg    <= '0;
            reseeding_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            seeded_length_reg <= seeded_length_next;
            pair_count_reg    <= pair_count_next;
            reseeding_reg     <= reseeding_next;
        end
    end

    // Read-modify-write of one entry, done in the compare cycle.
    always_comb
    begin
        result_t    r;
        logic [CNT_W-1:0] pc;
        ram_we             = 1'b0;
        seeded_length_next = seeded_length_reg;
        pair_count_next    = pair_count_reg;
        reseeding_next     = reseeding_reg;
        res_next[0]        = '0;
        res_next[1]        = '0;
        n_res              = 2'd0;
        r                  = '0;
        pc                 = pair_count_reg;

        if (state_reg == ST_CMP)
        begin
            case (cmd_reg)
                CMD_SCAN:
                begin
                    if (table_length_reg != '0)
                    begin
                        if (reseeding_reg || (table_length_reg != seeded_length_reg))
                        begin
                            reseeding_next = 1'b1;
                            ram_we         = entry_valid;
                            if (last_reg)
                            begin
                                seeded_length_next = table_length_reg;
                                reseeding_next     = 1'b0;
                                pair_count_next    = '0;
                            end
                        end
                        else
                        begin
                            if (entry_valid && (ram_rdata != val_reg))
                            begin
                                ram_we  = 1'b1;
                                r.index = idx_reg;
                                r.value = val_reg;
                                if (pair_count_reg < 7'(BEAT_CAP))
                                begin
                                    r.kind = KIND_PAIR;
                                    pc     = pc_inc;
                                end
                                else
                                begin
                                    r.kind = KIND_DROP;
                                end
                                res_next[0] = r;
                                n_res       = 2'd1;
                            end
                            pair_count_next = pc;
                            if (last_reg)
                            begin
                                if (pc != '0)
                                begin
                                    r              = '0;
                                    r.kind         = KIND_END;
                                    r.count        = pc;
                                    res_next[n_res[0]] = r;
                                    n_res          = n_res + 2'd1;
                                end
                                pair_count_next = '0;
                            end
                        end
                    end
                end
                CMD_SEED:
                begin
                    ram_we = entry_valid;
                    if (last_reg)
                    begin
                        seeded_length_next = table_length_reg;
                        reseeding_next     = 1'b0;
                        pair_count_next    = '0;
                    end
                end
                CMD_EMIT:
                begin
                    if (table_length_reg != '0)
                    begin
                        if (entry_valid)
                        begin
                            ram_we      = 1'b1;
                            r.kind      = KIND_PAIR;
                            r.index     = idx_reg;
                            r.value     = val_reg;
                            res_next[0] = r;
                            n_res       = 2'd1;
                            pc          = pc_inc;
                            // A full chunk closes its batch right away.
                            if (pc_inc >= 7'(CHUNK_SIZE))
                            begin
                                r           = '0;
                                r.kind      = KIND_END;
                                r.count     = pc_inc;
                                res_next[1] = r;
                                n_res       = 2'd2;
                                pc          = '0;
                            end
                        end
                        if (last_reg && (pc != '0))
                        begin
                            r                  = '0;
                            r.kind             = KIND_END;
                            r.count            = pc;
                            res_next[n_res[0]] = r;
                            n_res              = n_res + 2'd1;
                        end
                        pair_count_next = pc;
                        if (last_reg)
                        begin
                            seeded_length_next = table_length_reg;
                            reseeding_next     = 1'b0;
                            pair_count_next    = '0;
                        end
                    end
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = (n_res == 2'd0) ? ST_IDLE : ST_EMIT0;
            end
            ST_EMIT0:
            begin
                state_next = (n_res_reg == 2'd2) ? ST_EMIT1 : ST_IDLE;
            end
            ST_EMIT1:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_res_reg <= 2'd0;
        end
        else if (state_reg == ST_CMP)
        begin
            n_res_reg <= n_res;
        end
    end

    // Outputs
    always_comb
    begin
        result_t sel;
        sel    = res_reg[0];
        busy   = 1'b1;
        strobe = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_CMP:
            begin
                strobe = 1'b0;
            end
            ST_EMIT0:
            begin
                strobe = 1'b1;
            end
            ST_EMIT1:
            begin
                strobe = 1'b1;
                sel    = res_reg[1];
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
        kind        = sel.kind;
        out_index   = sel.index;
        out_value   = sel.value;
        batch_count = sel.count;
    end

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !strobe)
        else $error("accepted word did not hold off the next one");

    a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_END) |-> (batch_count != '0))
        else $error("batch end with empty batch");

    a_pair_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind != KIND_END) |-> (batch_count == '0))
        else $error("pair or drop word carries a batch count");

    a_max_two: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && $past(strobe) |-> !$past(strobe, 2))
        else $error("more than two results for one word");

endmodule
